// ===== rtl/core/uvs_pkg.sv =====
// Shared constants, types and tables of the UV-sphere vertex generator.
package uvs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SECTOR_COUNT  = 2'd0;
  localparam logic [1:0] REG_STACK_COUNT   = 2'd1;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

  localparam logic [7:0]  SECTOR_COUNT_RST  = 8'd36;
  localparam logic [7:0]  STACK_COUNT_RST   = 8'd18;
  localparam logic [15:0] SPHERE_RADIUS_RST = 16'd256;
  localparam logic [7:0]  SECTOR_COUNT_MIN  = 8'd3;
  localparam logic [7:0]  STACK_COUNT_MIN   = 8'd2;

  // Pipeline depths.
  localparam int DIV_LAT = 32;
  localparam int SC_LAT  = 16;
  localparam int LAST    = DIV_LAT + SC_LAT + 3;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [21:0] HALF_QUAD  = 22'h20_0000;
  localparam logic [22:0] QUAD       = 23'h40_0000;
  localparam logic [16:0] POS_MAX    = 17'd65535;

  // Reciprocals ceil(2^38 / k) of the Horner divisors.
  localparam logic [37:0] RECIP_SIN [5] = '{
    38'd2498890064, 38'd3817748708, 38'd6544712071, 38'd13743895348, 38'd45812984491
  };
  localparam logic [37:0] RECIP_COS [6] = '{
    38'd2082408386, 38'd3054198967, 38'd4908534053, 38'd9162596899,
    38'd22906492246, 38'd137438953472
  };

  typedef struct packed {
    logic [15:0] k1;
    logic [15:0] k2;
    logic        upper;
    logic        lower;
  } sb_t;

endpackage

// ===== rtl/core/uvs_div.sv =====
// Pipelined restoring divider of a 32-bit numerator by an 8-bit divisor, one bit per stage.
module uvs_div
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [7:0]  den,
  output logic [31:0] quo
);

  // The shift word holds the unused numerator bits on top and quotient bits below.
  logic [7:0]  rem [1:DIV_LAT-1];
  logic [31:0] w   [1:DIV_LAT];

  genvar k;
  generate
    for (k = 0; k < DIV_LAT; k++) begin : g_stage
      logic [7:0]  r_in;
      logic [31:0] w_in;
      logic [8:0]  t;
      logic        ge;
      logic [8:0]  diff;
      if (k == 0) begin : g_first
        assign r_in = 8'd0;
        assign w_in = num;
      end else begin : g_rest
        assign r_in = rem[k];
        assign w_in = w[k];
      end
      assign t    = {r_in, w_in[31]};
      assign ge   = t >= {1'b0, den};
      assign diff = t - {1'b0, den};
      always_ff @(posedge clk) begin
        if (en) begin
          w[k+1] <= {w_in[30:0], ge};
        end
      end
      if (k < DIV_LAT - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[k+1] <= ge ? diff[7:0] : t[7:0];
          end
        end
      end
    end
  endgenerate

  assign quo = w[DIV_LAT];

endmodule

// ===== rtl/core/uvs_sincos.sv =====
// Pipelined sine and cosine of a 24-bit phase by octant reduction and Horner series.
module uvs_sincos
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        phase,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  function automatic logic [29:0] mul_hi30(logic [29:0] a, logic [30:0] b);
    logic [60:0] p;
    p = {31'd0, a} * {30'd0, b};
    return p[59:30];
  endfunction

  function automatic logic [29:0] div_recip(logic [29:0] p, logic [37:0] m);
    logic [67:0] pr;
    pr = {38'd0, p} * {30'd0, m};
    return pr[67:38];
  endfunction

  logic [21:0] f;
  logic        swap_in;
  logic [22:0] comp;
  logic [21:0] x_a;
  logic [54:0] ang_prod;
  logic [29:0] a_b;
  logic [1:0]  quad_s [0:14];
  logic        swap_s [0:14];
  logic [29:0] a_s  [0:5];
  logic [29:0] a2_s [0:5];
  logic [29:0] a_m  [0:4];
  logic [29:0] a2_m [0:4];
  logic [29:0] ps [0:5];
  logic [29:0] pc [0:5];
  logic [30:0] ts [1:6];
  logic [30:0] tc [1:6];

  assign f        = phase[21:0];
  assign swap_in  = f > HALF_QUAD;
  assign comp     = QUAD - {1'b0, f};
  assign ang_prod = {33'd0, x_a} * {22'd0, TWO_PI_Q30};

  always_ff @(posedge clk) begin
    if (en) begin
      x_a       <= swap_in ? comp[21:0] : f;
      quad_s[0] <= phase[23:22];
      swap_s[0] <= swap_in;
      a_b       <= ang_prod[53:24];
      a_s[0]    <= a_b;
      a2_s[0]   <= mul_hi30(a_b, {1'b0, a_b});
      for (int n = 1; n < 15; n++) begin
        quad_s[n] <= quad_s[n-1];
        swap_s[n] <= swap_s[n-1];
      end
    end
  end

  genvar n;
  generate
    for (n = 0; n < 6; n++) begin : g_step
      logic [30:0] tin_s;
      logic [30:0] tin_c;
      if (n == 0) begin : g_one
        assign tin_s = ONE_Q30;
        assign tin_c = ONE_Q30;
      end else begin : g_prev
        assign tin_s = ts[n];
        assign tin_c = tc[n];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          pc[n] <= mul_hi30(a2_s[n], tin_c);
          tc[n+1] <= ONE_Q30 - {1'b0, div_recip(pc[n], RECIP_COS[n])};
        end
      end
      if (n < 5) begin : g_sin
        always_ff @(posedge clk) begin
          if (en) begin
            ps[n]   <= mul_hi30(a2_s[n], tin_s);
            a_m[n]  <= a_s[n];
            a2_m[n] <= a2_s[n];
            ts[n+1] <= ONE_Q30 - {1'b0, div_recip(ps[n], RECIP_SIN[n])};
            a_s[n+1]  <= a_m[n];
            a2_s[n+1] <= a2_m[n];
          end
        end
      end else begin : g_sin_last
        // The sine series ends with a multiply by the angle itself.
        always_ff @(posedge clk) begin
          if (en) begin
            ps[n]   <= mul_hi30(a_s[n], tin_s);
            ts[n+1] <= {1'b0, ps[n]};
          end
        end
      end
    end
  endgenerate

  logic signed [31:0] sq;
  logic signed [31:0] cq;

  always_comb begin
    sq = swap_s[14] ? $signed({1'b0, tc[6]}) : $signed({1'b0, ts[6]});
    cq = swap_s[14] ? $signed({1'b0, ts[6]}) : $signed({1'b0, tc[6]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_s[14])
        2'd0: begin
          sin_q <= sq;
          cos_q <= cq;
        end
        2'd1: begin
          sin_q <= cq;
          cos_q <= -sq;
        end
        2'd2: begin
          sin_q <= -sq;
          cos_q <= -cq;
        end
        default: begin
          sin_q <= -cq;
          cos_q <= sq;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/uv_sphere_vertex_generator.sv =====
// Top level of the UV-sphere vertex generator.
//
//  channel  direction  handshake         payload
//  s_*      in         tvalid / tready   grid point (stack, sector)
//  m_*      out        tvalid / tready   vertex, normal, texture, corners, flags
//  cfg_*    in         cfg_we            register index and write data
//
// One point enters per cycle while the output is not stalled; each result passes
// through the input stage, the 32 one-bit divider stages, the 16 sine/cosine stages
// and three product and output stages.
// Reset is synchronous, clears the valid bits and loads the configuration defaults.
// The whole pipeline advances when the output register is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // stack_index[7:0], sector_index[15:8]
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_s, tex_t,
  // corner_this_row, corner_next_row, upper_tri_valid, lower_tri_valid, zero pad
  output logic [167:0] m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  logic [7:0]  sector_count;
  logic [7:0]  stack_count;
  logic [15:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count  <= SECTOR_COUNT_RST;
      stack_count   <= STACK_COUNT_RST;
      sphere_radius <= SPHERE_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SECTOR_COUNT:  sector_count  <= cfg_wdata[7:0];
        REG_STACK_COUNT:   stack_count   <= cfg_wdata[7:0];
        REG_SPHERE_RADIUS: sphere_radius <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [7:0] sc_eff;
  logic [7:0] st_eff;
  assign sc_eff = (sector_count < SECTOR_COUNT_MIN) ? SECTOR_COUNT_MIN : sector_count;
  assign st_eff = (stack_count < STACK_COUNT_MIN) ? STACK_COUNT_MIN : stack_count;

  logic v [0:LAST];
  logic adv;
  assign adv      = !v[LAST] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n <= LAST; n++) v[n] <= 1'b0;
    end else if (adv) begin
      v[0] <= s_tvalid;
      for (int n = 1; n <= LAST; n++) v[n] <= v[n-1];
    end
  end

  // Input stage with clamped indexes.
  logic [7:0] i_r;
  logic [7:0] j_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      i_r <= (s_tdata[7:0] > st_eff) ? st_eff : s_tdata[7:0];
      j_r <= (s_tdata[15:8] > sc_eff) ? sc_eff : s_tdata[15:8];
    end
  end

  // Quad corners and triangle flags.
  sb_t         sb_in;
  logic [15:0] k1;
  logic        inner;
  assign k1    = 16'({8'd0, i_r} * ({8'd0, sc_eff} + 16'd1)) + {8'd0, j_r};
  assign inner = (i_r < st_eff) && (j_r < sc_eff);
  always_comb begin
    sb_in.k1    = k1;
    sb_in.k2    = (i_r < st_eff) ? k1 + {8'd0, sc_eff} + 16'd1 : 16'd0;
    sb_in.upper = inner && (i_r != 8'd0);
    sb_in.lower = inner && (i_r != st_eff - 8'd1);
  end

  sb_t sb_p [1:LAST];
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_p[1] <= sb_in;
      for (int n = 2; n <= LAST; n++) sb_p[n] <= sb_p[n-1];
    end
  end

  // Phases and texture coordinates all come from rounded divisions.
  logic [31:0] q_phi;
  logic [31:0] q_th;
  logic [31:0] q_s;
  logic [31:0] q_t;

  uvs_div u_div_phi (
    .clk(clk), .en(adv),
    .num({j_r, 24'd0} + {25'd0, sc_eff[7:1]}), .den(sc_eff), .quo(q_phi)
  );
  uvs_div u_div_th (
    .clk(clk), .en(adv),
    .num({1'b0, i_r, 23'd0} + {25'd0, st_eff[7:1]}), .den(st_eff), .quo(q_th)
  );
  uvs_div u_div_s (
    .clk(clk), .en(adv),
    .num({9'd0, j_r, 15'd0} + {25'd0, sc_eff[7:1]}), .den(sc_eff), .quo(q_s)
  );
  uvs_div u_div_t (
    .clk(clk), .en(adv),
    .num({9'd0, i_r, 15'd0} + {25'd0, st_eff[7:1]}), .den(st_eff), .quo(q_t)
  );

  logic [15:0] tex_s_p [DIV_LAT+1:LAST];
  logic [15:0] tex_t_p [DIV_LAT+1:LAST];
  always_ff @(posedge clk) begin
    if (adv) begin
      tex_s_p[DIV_LAT+1] <= q_s[15:0];
      tex_t_p[DIV_LAT+1] <= q_t[15:0];
      for (int n = DIV_LAT + 2; n <= LAST; n++) begin
        tex_s_p[n] <= tex_s_p[n-1];
        tex_t_p[n] <= tex_t_p[n-1];
      end
    end
  end

  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] sth;
  logic signed [31:0] cth;

  uvs_sincos u_sc_phi (.clk(clk), .en(adv), .phase(q_phi[23:0]), .sin_q(sp), .cos_q(cp));
  uvs_sincos u_sc_th (.clk(clk), .en(adv), .phase(q_th[23:0]), .sin_q(sth), .cos_q(cth));

  function automatic logic [30:0] mag31(logic signed [31:0] v_in);
    logic [31:0] m;
    m = v_in[31] ? 32'(-v_in) : 32'(v_in);
    return m[30:0];
  endfunction

  function automatic logic signed [31:0] mul_q30(logic signed [31:0] a, logic signed [31:0] b);
    logic [61:0] p;
    logic [61:0] r;
    logic [31:0] m;
    p = {31'd0, mag31(a)} * {31'd0, mag31(b)};
    r = (p + 62'h2000_0000) >> 30;
    m = r[31:0];
    return (a[31] != b[31]) ? $signed(-m) : $signed(m);
  endfunction

  // Unit vector.
  logic signed [31:0] u_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      u_r[0] <= mul_q30(sth, cp);
      u_r[1] <= mul_q30(sth, sp);
      u_r[2] <= cth;
    end
  end

  // Radius product and normal rounding.
  logic [46:0]        pm_r  [3];
  logic               neg_r [3];
  logic signed [15:0] nrm_r [3];
  logic signed [15:0] nrm_o [3];
  logic signed [16:0] pos_o [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 3; n++) begin
        logic [31:0] nm;
        nm       = ({1'b0, mag31(u_r[n])} + 32'h8000) >> 16;
        pm_r[n]  <= {16'd0, mag31(u_r[n])} * {31'd0, sphere_radius};
        neg_r[n] <= u_r[n][31];
        nrm_r[n] <= u_r[n][31] ? $signed(-nm[15:0]) : $signed(nm[15:0]);
      end
    end
  end

  // Position rounding and saturation, into the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 3; n++) begin
        logic [46:0] pr;
        logic [16:0] pc;
        pr = (pm_r[n] + 47'h2000_0000) >> 30;
        pc = (pr > {30'd0, POS_MAX}) ? POS_MAX : pr[16:0];
        pos_o[n] <= neg_r[n] ? $signed(-pc) : $signed(pc);
        nrm_o[n] <= nrm_r[n];
      end
    end
  end

  assign m_tdata = {3'd0, sb_p[LAST].lower, sb_p[LAST].upper, sb_p[LAST].k2, sb_p[LAST].k1,
                    tex_t_p[LAST], tex_s_p[LAST], nrm_o[2], nrm_o[1], nrm_o[0],
                    pos_o[2], pos_o[1], pos_o[0]};

  a_corner_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (sb_p[LAST].upper || sb_p[LAST].lower)
      |-> sb_p[LAST].k2 == sb_p[LAST].k1 + {8'd0, sc_eff} + 16'd1)
    else $error("corner indexes disagree with the sector count");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (nrm_o[2] <= 16'sd16384) && (nrm_o[2] >= -16'sd16384))
    else $error("normal component out of unit range");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[0])
    else $error("accepted request did not enter the pipeline");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && sb_p[LAST].lower |-> sb_p[LAST].k2 != 16'd0)
    else $error("lower triangle flagged on the last row");

endmodule
